// File: rtl/core/buzzer_pulse_train_sequencer_unit_assert.svh
// Assertion macros for the buzzer pulse train sequencer.
// Used by the top level only; needs no package.
`ifndef BUZZER_PULSE_TRAIN_SEQUENCER_UNIT_ASSERT_SVH
`define BUZZER_PULSE_TRAIN_SEQUENCER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication under an active low reset.
`define BPTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
// Next-cycle implication under an active low reset.
`define BPTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`else
`define BPTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BPTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/bpts_pkg.sv
// Package for the buzzer pulse train sequencer: types, constants and the
// command/status structs shared by controller and datapath. No dependencies.
package bpts_pkg;

  // Train phase kept in the datapath.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ARMED = 2'd1,
    PH_ON    = 2'd2,
    PH_OFF   = 2'd3
  } phase_t;

  // Controller sequence states.
  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_EVAL = 2'd1,
    CS_DIV  = 2'd2,
    CS_FIN  = 2'd3
  } ctrl_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;
    logic apply;
    logic div_step;
    logic publish;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic arm;
    logic div_last;
    logic out_free;
  } sts_t;

  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned REM_W      = 14;
  localparam int unsigned DVS_W      = 15;
  localparam int unsigned SHIFT_W    = DVS_W + COUNT_W;
  localparam int unsigned STEP_W     = 3;

  localparam logic [COUNT_W-1:0] ON_TICKS       = 8'(10000 / 728);
  localparam logic [REM_W-1:0]   RATE_NUMERATOR = 14'd10000;
  localparam logic [DVS_W-1:0]   RATE_FACTOR    = 15'd73;
  localparam logic [STEP_W-1:0]  STEP_FIRST     = 3'd7;
  localparam logic [STEP_W-1:0]  STEP_LAST      = 3'd0;
  localparam logic [COUNT_W-1:0] OFF_MIN        = 8'd1;
  // Off time for a rate of zero, which counts as a rate of one.
  localparam logic [COUNT_W-1:0] OFF_DEFAULT    = 8'(10000 / 73 - 10000 / 728);

endpackage

// File: rtl/core/bpts_ctrl.sv
// Controller of the buzzer pulse train sequencer: sequences capture, update,
// off-time division and result hand-off. Depends on bpts_pkg.
module bpts_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  bpts_pkg::sts_t sts,
  output bpts_pkg::cmd_t cmd
);

  bpts_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpts_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      bpts_pkg::CS_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = bpts_pkg::CS_EVAL;
        end
      end
      bpts_pkg::CS_EVAL: begin
        cmd.apply = 1'b1;
        // An armed start needs a fresh off time for its rate.
        state_nxt = sts.arm ? bpts_pkg::CS_DIV : bpts_pkg::CS_FIN;
      end
      bpts_pkg::CS_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = bpts_pkg::CS_FIN;
        end
      end
      bpts_pkg::CS_FIN: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = bpts_pkg::CS_IDLE;
        end
      end
      default: begin
        state_nxt = bpts_pkg::CS_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/bpts_dp.sv
// Datapath of the buzzer pulse train sequencer: item register, train state,
// off-time divider and output register. Depends on bpts_pkg.
module bpts_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tuser,
  input  logic [bpts_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bpts_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  bpts_pkg::cmd_t                      cmd,
  output bpts_pkg::sts_t                      sts
);

  localparam int unsigned CW = bpts_pkg::COUNT_W;

  // Captured item (payload, no reset).
  logic          func_r, pressed_r, manual_r, level_r, running_r;
  logic [CW-1:0] total_in_r, rate_in_r;

  // Train state.
  bpts_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0] stored_total_r, stored_total_nxt;
  logic [CW-1:0] pulse_number_r, pulse_number_nxt;
  logic [CW-1:0] countdown_r, countdown_nxt;
  logic          buzzer_r, buzzer_nxt;
  logic [CW-1:0] off_len_r, off_len_nxt;

  // Off-time divider: 10000 / (73 * rate), one quotient bit per cycle.
  logic [bpts_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [bpts_pkg::DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [CW-1:0]               quo_r, quo_nxt;
  logic [bpts_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [bpts_pkg::SHIFT_W-1:0] shifted;
  logic                        fits;
  logic [CW-1:0]               rate_eff;
  logic [CW-1:0]               cd_dec;

  // Pending result and output register.
  logic          res_buzz, res_acc, res_rep;
  logic [CW-1:0] res_cnt;
  logic          res_buzz_r, res_acc_r, res_rep_r;
  logic [CW-1:0] res_cnt_r;
  logic          out_valid_r;
  logic [bpts_pkg::OUT_DATA_W-1:0] out_data_r;

  assign sts.arm      = func_r && manual_r && pressed_r;
  assign sts.div_last = (step_r == bpts_pkg::STEP_LAST);
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign rate_eff = (rate_in_r == '0) ? CW'(1) : rate_in_r;
  assign shifted  = bpts_pkg::SHIFT_W'(dvs_r) << step_r;
  assign fits     = (bpts_pkg::SHIFT_W'(rem_r) >= shifted);
  assign cd_dec   = countdown_r - CW'(1);

  always_comb begin
    phase_nxt        = phase_r;
    stored_total_nxt = stored_total_r;
    pulse_number_nxt = pulse_number_r;
    countdown_nxt    = countdown_r;
    buzzer_nxt       = buzzer_r;
    off_len_nxt      = off_len_r;
    rem_nxt          = rem_r;
    dvs_nxt          = dvs_r;
    quo_nxt          = quo_r;
    step_nxt         = step_r;
    res_acc          = 1'b0;
    res_rep          = 1'b0;
    res_cnt          = '0;

    if (cmd.apply) begin
      if (func_r) begin
        if (sts.arm) begin
          stored_total_nxt = total_in_r;
          phase_nxt        = bpts_pkg::PH_ARMED;
          res_acc          = 1'b1;
          rem_nxt          = bpts_pkg::RATE_NUMERATOR;
          dvs_nxt          = bpts_pkg::DVS_W'(rate_eff) * bpts_pkg::RATE_FACTOR;
          quo_nxt          = '0;
          step_nxt         = bpts_pkg::STEP_FIRST;
        end
      end else if (!running_r) begin
        buzzer_nxt = 1'b0;
        phase_nxt  = bpts_pkg::PH_IDLE;
      end else if (phase_r != bpts_pkg::PH_IDLE) begin
        if (!pressed_r || !manual_r) begin
          // Button released or manual mode left: abort with a report.
          buzzer_nxt = 1'b0;
          res_rep    = 1'b1;
          res_cnt    = pulse_number_r;
          phase_nxt  = bpts_pkg::PH_IDLE;
        end else begin
          unique case (phase_r)
            bpts_pkg::PH_ARMED: begin
              pulse_number_nxt = CW'(1);
              buzzer_nxt       = 1'b1;
              countdown_nxt    = bpts_pkg::ON_TICKS;
              phase_nxt        = bpts_pkg::PH_ON;
            end
            bpts_pkg::PH_ON: begin
              countdown_nxt = cd_dec;
              if (cd_dec == '0) begin
                buzzer_nxt    = 1'b0;
                countdown_nxt = off_len_r;
                phase_nxt     = bpts_pkg::PH_OFF;
              end
            end
            bpts_pkg::PH_OFF: begin
              countdown_nxt = cd_dec;
              if (cd_dec == '0) begin
                if (pulse_number_r == stored_total_r) begin
                  res_rep   = 1'b1;
                  res_cnt   = pulse_number_r;
                  phase_nxt = bpts_pkg::PH_IDLE;
                end else begin
                  pulse_number_nxt = pulse_number_r + CW'(1);
                  buzzer_nxt       = 1'b1;
                  countdown_nxt    = bpts_pkg::ON_TICKS;
                  phase_nxt        = bpts_pkg::PH_ON;
                end
              end
            end
            bpts_pkg::PH_IDLE: begin
              phase_nxt = bpts_pkg::PH_IDLE;
            end
          endcase
        end
      end else begin
        buzzer_nxt = manual_r && level_r;
      end
    end

    if (cmd.div_step) begin
      if (fits) begin
        rem_nxt = rem_r - shifted[bpts_pkg::REM_W-1:0];
      end
      quo_nxt  = {quo_r[CW-2:0], fits};
      step_nxt = step_r - bpts_pkg::STEP_W'(1);
      if (sts.div_last) begin
        // Periods of thirteen ticks or less leave no off time and clamp it to a single tick.
        off_len_nxt = (quo_nxt <= bpts_pkg::ON_TICKS) ? bpts_pkg::OFF_MIN
                                                      : quo_nxt - bpts_pkg::ON_TICKS;
      end
    end

    res_buzz = buzzer_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r     <= in_tuser;
      total_in_r <= in_tdata[7:0];
      rate_in_r  <= in_tdata[15:8];
      pressed_r  <= in_tdata[16];
      manual_r   <= in_tdata[17];
      level_r    <= in_tdata[18];
      running_r  <= in_tdata[19];
    end
    if (cmd.apply) begin
      res_buzz_r <= res_buzz;
      res_acc_r  <= res_acc;
      res_rep_r  <= res_rep;
      res_cnt_r  <= res_cnt;
    end
    if (cmd.publish) begin
      out_data_r <= {5'b0, res_cnt_r, res_rep_r, res_acc_r, res_buzz_r};
    end
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= bpts_pkg::PH_IDLE;
      stored_total_r <= '0;
      pulse_number_r <= '0;
      countdown_r    <= '0;
      buzzer_r       <= 1'b0;
      off_len_r      <= bpts_pkg::OFF_DEFAULT;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      stored_total_r <= stored_total_nxt;
      pulse_number_r <= pulse_number_nxt;
      countdown_r    <= countdown_nxt;
      buzzer_r       <= buzzer_nxt;
      off_len_r      <= off_len_nxt;
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/buzzer_pulse_train_sequencer_unit.sv
// Top level of the buzzer pulse train sequencer: controller plus datapath.
// Depends on bpts_pkg, bpts_ctrl, bpts_dp and the assertion macro header.
//
// Usage: every input item on the in_ channel yields exactly one result item
// on the out_ channel. in_tuser selects the kind of item: 0 is a periodic
// tick that advances the buzzer, 1 is a start command that arms a pulse train
// when manual mode and the request button are both active.
// Sequence: a tick item is captured in the idle state, applied in the evaluate
// state and published from the finish state; an accepted start item also passes
// the divide state, because the off time for its frame rate is divided out one
// quotient bit per cycle in the datapath divider. The controller handles one item
// at a time and takes a new item only once it is back in its idle state.
// The result sits in an output register, so a new item is accepted while the
// previous result waits. If the receiver stalls, at most one more item is
// processed and then held until the output register frees up.
// Reset (rst_n low, synchronous) returns the train to idle with the buzzer
// off, the pulse counter and stored total at zero, and the output empty.
`include "buzzer_pulse_train_sequencer_unit_assert.svh"

module buzzer_pulse_train_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0 up: pulse_total[7:0], frames_per_second[15:8],
  // request_pressed[16], manual_mode[17], manual_level[18],
  // board_running[19], zero fill[23:20].
  input  logic [23:0] in_tdata,
  // Fields: func[0].
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0 up: buzzer_on[0], start_accepted[1], report_valid[2],
  // pulses_reported[10:3], zero fill[15:11].
  output logic [15:0] out_tdata
);

  bpts_pkg::cmd_t cmd;
  bpts_pkg::sts_t sts;

  // The controller only sequences; all train state lives in the datapath.
  bpts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpts_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Once an item is taken, the block is busy for at least the next cycle.
  `BPTS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // Publishing a result always leaves a valid item on the output.
  `BPTS_ASSERT_NXT(a_publish_valid, clk, rst_n, cmd.publish, out_tvalid)
  // An item that does not arm a train never runs the divider.
  `BPTS_ASSERT_NXT(a_no_div_unarmed, clk, rst_n, cmd.apply && !sts.arm, !cmd.div_step)
  // A result is only moved into the output register when it has room.
  `BPTS_ASSERT_IMP(a_publish_room, clk, rst_n, cmd.publish, sts.out_free)

endmodule
